// ===== hw/rtl/fdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsc_pkg
// Shared types, register indexes and constants for the four-digit segment
// counter display.
// ----------------------------------------------------------------------------
package fdsc_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_DWELL    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_PERIOD = 8'd1;

  localparam logic [15:0] DWELL_RESET   = 16'd2;
  localparam logic [15:0] LOCKOUT_RESET = 16'd750;

  // Counter start value in binary, divided by ten, and as BCD digits.
  localparam logic [13:0]      COUNT_START     = 14'd9999;
  localparam logic [9:0]       TENS_START      = 10'd999;
  localparam logic [3:0][3:0]  BCD_START       = {4'd9, 4'd9, 4'd9, 4'd9};
  localparam logic [13:0]      COUNT_MAX       = 14'd9999;
  localparam logic [13:0]      TENS_MAX        = 14'd999;

  // Number of decimal digits the counter can carry.
  localparam int BCD_DIGITS = 4;

  typedef struct packed {
    logic button_low;
    logic decrement_pulse;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  segment_lines;
    logic [3:0]  digit_enable;
    logic [13:0] shown_value;
    logic        divide_mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0] dwell_ticks;
    logic [15:0] lockout_ticks;
  } cfg_regs_t;

  // Counter state handed from the tick logic to the display logic.
  typedef struct packed {
    logic [13:0]     count_value;
    logic [9:0]      tens_value;
    logic [3:0][3:0] count_bcd;
    logic            scale_flag;
  } tick_state_t;

  // Segment pattern for one decimal digit, bit0 = a through bit6 = g.
  function automatic logic [6:0] seg_decode(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h67;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

  // Decrement a nonzero BCD number by one, borrowing digit by digit.
  function automatic logic [3:0][3:0] bcd_decrement(input logic [3:0][3:0] value);
    logic [3:0][3:0] res;
    logic            borrow;
    res    = value;
    borrow = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (borrow) begin
        if (value[i] == 4'd0) begin
          res[i] = 4'd9;
        end else begin
          res[i] = value[i] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/fdsc_tick.sv =====
// ----------------------------------------------------------------------------
// fdsc_tick
// Per-item state update: lockout timer, saturating down counter kept in
// binary, divided by ten and BCD, divide mode toggle and digit scan.
// ----------------------------------------------------------------------------
module fdsc_tick #(
  parameter int DIGIT_COUNT = 4,
  parameter int SCAN_W      = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  fdsc_pkg::in_item_t  item,
  input  fdsc_pkg::cfg_regs_t cfg,
  output fdsc_pkg::tick_state_t state,
  output logic [SCAN_W-1:0]   show_pos
);

  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(DIGIT_COUNT - 1);

  fdsc_pkg::tick_state_t state_next;
  logic                  button_locked;
  logic                  button_locked_next;
  logic [15:0]           lockout_counter;
  logic [15:0]           lockout_counter_next;
  logic [15:0]           dwell_counter;
  logic [15:0]           dwell_counter_next;
  logic [SCAN_W-1:0]     scan_position;
  logic [SCAN_W-1:0]     scan_position_next;
  logic [15:0]           period;
  logic [15:0]           dwell;

  // A zero period or dwell behaves as one.
  assign period = (cfg.lockout_ticks == 16'd0) ? 16'd1 : cfg.lockout_ticks;
  assign dwell  = (cfg.dwell_ticks == 16'd0) ? 16'd1 : cfg.dwell_ticks;

  // Next state for one accepted item.
  always_comb begin
    state_next           = state;
    button_locked_next   = button_locked;
    lockout_counter_next = lockout_counter;
    dwell_counter_next   = dwell_counter;
    scan_position_next   = scan_position;

    // The lockout timer runs freely and re-arms the button at each wrap.
    if ({1'b0, lockout_counter} + 17'd1 >= {1'b0, period}) begin
      lockout_counter_next = 16'd0;
      button_locked_next   = 1'b0;
    end else begin
      lockout_counter_next = lockout_counter + 16'd1;
    end

    // The counter holds at zero; the tens value drops when units borrow.
    if (item.decrement_pulse && (state.count_value != 14'd0)) begin
      state_next.count_value = state.count_value - 14'd1;
      state_next.count_bcd   = fdsc_pkg::bcd_decrement(state.count_bcd);
      if (state.count_bcd[0] == 4'd0) begin
        state_next.tens_value = state.tens_value - 10'd1;
      end
    end

    // A press while armed toggles the mode and locks the button.
    if (item.button_low && !button_locked_next) begin
      button_locked_next    = 1'b1;
      state_next.scale_flag = ~state.scale_flag;
    end

    // The scan moves on after the dwell time.
    if ({1'b0, dwell_counter} + 17'd1 >= {1'b0, dwell}) begin
      dwell_counter_next = 16'd0;
      scan_position_next = (scan_position == SCAN_LAST) ? '0 : scan_position + 1'b1;
    end else begin
      dwell_counter_next = dwell_counter + 16'd1;
    end
  end

  // State registers; show_pos keeps the digit chosen for the last item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.count_value <= fdsc_pkg::COUNT_START;
      state.tens_value  <= fdsc_pkg::TENS_START;
      state.count_bcd   <= fdsc_pkg::BCD_START;
      state.scale_flag  <= 1'b0;
      button_locked     <= 1'b0;
      lockout_counter   <= 16'd0;
      dwell_counter     <= 16'd0;
      scan_position     <= '0;
      show_pos          <= '0;
    end else if (accept) begin
      state           <= state_next;
      button_locked   <= button_locked_next;
      lockout_counter <= lockout_counter_next;
      dwell_counter   <= dwell_counter_next;
      scan_position   <= scan_position_next;
      show_pos        <= scan_position;
    end
  end

endmodule

// ===== hw/rtl/fdsc_display.sv =====
// ----------------------------------------------------------------------------
// fdsc_display
// Builds one result: shown value, digit selection, leading zero blanking and
// segment decode for the digit under the scan.
// ----------------------------------------------------------------------------
module fdsc_display #(
  parameter int DIGIT_COUNT = 4,
  parameter int SCAN_W      = 2
) (
  input  fdsc_pkg::tick_state_t state,
  input  logic [SCAN_W-1:0]     show_pos,
  output fdsc_pkg::out_item_t   result
);

  localparam logic [SCAN_W-1:0] POS_LAST = SCAN_W'(DIGIT_COUNT - 1);

  logic [3:0][3:0]   shown_bcd;
  logic [SCAN_W-1:0] place;
  logic [3:0]        place_ext;
  logic [3:0]        pos_ext;
  logic              upper_nonzero;
  logic              blank;

  // Place of the scanned digit counted from the units.
  assign place     = POS_LAST - show_pos;
  assign place_ext = 4'(place);
  assign pos_ext   = 4'(show_pos);

  // Divide by ten drops the units digit of the BCD count.
  always_comb begin
    for (int i = 0; i < fdsc_pkg::BCD_DIGITS; i++) begin
      if (!state.scale_flag) begin
        shown_bcd[i] = state.count_bcd[i];
      end else if (i == fdsc_pkg::BCD_DIGITS - 1) begin
        shown_bcd[i] = 4'd0;
      end else begin
        shown_bcd[i] = state.count_bcd[i+1];
      end
    end
  end

  // A digit other than the units is a leading zero when it and every digit above it are zero.
  always_comb begin
    upper_nonzero = 1'b0;
    for (int i = 0; i < fdsc_pkg::BCD_DIGITS; i++) begin
      if ((4'(i) >= place_ext) && (shown_bcd[i] != 4'd0)) begin
        upper_nonzero = 1'b1;
      end
    end
    blank = (place_ext >= 4'd4) || ((place_ext != 4'd0) && !upper_nonzero);
  end

  // Assemble the result item.
  always_comb begin
    result.shown_value   = state.scale_flag ? 14'(state.tens_value) : state.count_value;
    result.divide_mode   = state.scale_flag;
    result.segment_lines = blank ? 7'd0 : fdsc_pkg::seg_decode(shown_bcd[place_ext[1:0]]);
    result.digit_enable  = (pos_ext < 4'd4) ? (4'd1 << pos_ext[1:0]) : 4'd0;
  end

endmodule

// ===== hw/rtl/four_digit_segment_counter_display_top.sv =====
// ----------------------------------------------------------------------------
// four_digit_segment_counter_display_top
// Multiplexed four-digit seven-segment down counter display, one item per
// millisecond tick.
// ----------------------------------------------------------------------------
//  Channel  | Signals                        | Direction | Handshake
//  ---------+--------------------------------+-----------+---------------------
//  in       | in_valid, in_stall, in_item    | input     | valid high, stall low
//  out      | out_valid, out_stall, out_item | output    | valid high, stall low
//  cfg      | cfg_valid, cfg_ready, cfg_*    | input     | valid and ready high
//
//  The block takes one item every cycle while in_stall is low; its result passes
//  through the counter state registers and then the result register.
//  Reset (rst, synchronous) loads the counter with 9999 and the registers
//  with their defaults; no sweep follows, so items are taken at once.
//  A stalled result holds the result register, and one further item waits in
//  the state stage before in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module four_digit_segment_counter_display_top #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fdsc_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fdsc_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fdsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SCAN_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  fdsc_pkg::cfg_regs_t   cfg;
  fdsc_pkg::tick_state_t state;
  fdsc_pkg::out_item_t   result;
  logic [SCAN_W-1:0]     show_pos;
  logic                  in_accept;
  logic                  stage_valid;
  logic                  out_load;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell_ticks   <= fdsc_pkg::DWELL_RESET;
      cfg.lockout_ticks <= fdsc_pkg::LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdsc_pkg::CFG_DIGIT_DWELL:    cfg.dwell_ticks   <= cfg_data;
        fdsc_pkg::CFG_LOCKOUT_PERIOD: cfg.lockout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow: the state stage moves into the result register when free.
  assign out_load  = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  fdsc_tick #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .SCAN_W      (SCAN_W)
  ) u_tick (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_accept),
    .item     (in_item),
    .cfg      (cfg),
    .state    (state),
    .show_pos (show_pos)
  );

  fdsc_display #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .SCAN_W      (SCAN_W)
  ) u_display (
    .state    (state),
    .show_pos (show_pos),
    .result   (result)
  );

  // Stage valid and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      stage_valid <= in_accept || (stage_valid && !out_load);
      out_valid   <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= result;
    end
  end

endmodule

// ===== hw/rtl/fdsc_checker.sv =====
// ----------------------------------------------------------------------------
// fdsc_checker
// Port-level checks on the result channel of the segment counter display.
// ----------------------------------------------------------------------------
module fdsc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input fdsc_pkg::out_item_t out_item
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed or dropped");

  // At most one digit is selected at a time.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_item.digit_enable))
    else $error("more than one digit enabled");

  // The counter never wraps past its start value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.shown_value <= fdsc_pkg::COUNT_MAX)
    else $error("shown value above 9999");

  // In divide mode the shown value is at most three digits.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.divide_mode |-> out_item.shown_value <= fdsc_pkg::TENS_MAX)
    else $error("divided value above 999");

endmodule

bind four_digit_segment_counter_display_top fdsc_checker u_fdsc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
